// ===== hdl/pbu_pkg.sv =====
// Package for the pixel blend unit: blend mode codes and the inter-stage lane record.
`default_nettype none
package pbu_pkg;

   localparam int unsigned ChanWidth = 8;
   localparam int unsigned ModeWidth = 3;
   localparam int unsigned NumWidth  = 16;
   localparam int unsigned NumChans  = 3;

   localparam logic [ModeWidth-1:0] MODE_MULTIPLY = 3'd0;
   localparam logic [ModeWidth-1:0] MODE_SUBTRACT = 3'd1;
   localparam logic [ModeWidth-1:0] MODE_ADD      = 3'd2;
   localparam logic [ModeWidth-1:0] MODE_SCREEN   = 3'd3;
   localparam logic [ModeWidth-1:0] MODE_OVERLAY  = 3'd4;

   localparam logic [ChanWidth-1:0] CHAN_MAX = 8'd255;

   typedef logic [ChanWidth-1:0] chan_type;

   typedef struct packed {
      logic [NumWidth-1:0] num;
      logic                use_div;
      logic                invert;
      chan_type            direct;
   } mid_type;

endpackage
`default_nettype wire

// ===== hdl/pbu_prod.sv =====
// First lane stage: product of the selected operands and the clamped add and subtract results.
`default_nettype none
module pbu_prod (
   input  wire logic                             clock,
   input  wire logic [pbu_pkg::ModeWidth-1:0]    mode,
   input  wire pbu_pkg::chan_type                chan_a,
   input  wire pbu_pkg::chan_type                chan_b,
   output pbu_pkg::mid_type                      mid_ff
);
   import pbu_pkg::*;

   chan_type                op_x;
   chan_type                op_y;
   logic [2*ChanWidth-1:0]  prod;
   logic [2*ChanWidth:0]    prod2;
   logic [ChanWidth:0]      sum;
   mid_type                 mid_in;

   always_comb begin
      op_x = chan_a;
      op_y = chan_b;
      unique case (mode)
         MODE_SCREEN: begin
            op_x = ~chan_a;
            op_y = ~chan_b;
         end
         MODE_OVERLAY: begin
            if (chan_b[ChanWidth-1]) begin
               op_x = ~chan_a;
               op_y = ~chan_b;
            end
         end
         default: begin
            op_x = chan_a;
            op_y = chan_b;
         end
      endcase
   end

   assign prod  = op_x * op_y;
   assign prod2 = {prod, 1'b0};
   assign sum   = {1'b0, chan_a} + {1'b0, chan_b};

   always_comb begin
      mid_in.num     = '0;
      mid_in.use_div = 1'b0;
      mid_in.invert  = 1'b0;
      mid_in.direct  = '0;
      unique case (mode)
         MODE_MULTIPLY: begin
            mid_in.num     = prod + NumWidth'(127);
            mid_in.use_div = 1'b1;
         end
         MODE_SCREEN: begin
            mid_in.num     = prod + NumWidth'(127);
            mid_in.use_div = 1'b1;
            mid_in.invert  = 1'b1;
         end
         MODE_OVERLAY: begin
            mid_in.use_div = 1'b1;
            if (chan_b[ChanWidth-1]) begin
               mid_in.num    = prod2[NumWidth-1:0] + NumWidth'(254);
               mid_in.invert = 1'b1;
            end else begin
               mid_in.num = prod2[NumWidth-1:0];
            end
         end
         MODE_SUBTRACT: begin
            mid_in.direct = (chan_a > chan_b) ? chan_a - chan_b : '0;
         end
         MODE_ADD: begin
            mid_in.direct = sum[ChanWidth] ? CHAN_MAX : sum[ChanWidth-1:0];
         end
         default: begin
            mid_in.direct = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mid_ff <= mid_in;
   end

endmodule
`default_nettype wire

// ===== hdl/pbu_scale.sv =====
// Second lane stage: exact divide by 255 through a reciprocal multiply and final result select.
`default_nettype none
module pbu_scale (
   input  wire logic                 clock,
   input  wire pbu_pkg::mid_type     mid,
   output pbu_pkg::chan_type         res_ff
);
   import pbu_pkg::*;

   logic [NumWidth:0]       num_inc;
   logic [NumWidth+8:0]     recip;
   chan_type                quot;
   chan_type                res_in;

   // floor(n / 255) = ((n + 1) * 257) >> 16 for n below 65535
   assign num_inc = {1'b0, mid.num} + (NumWidth+1)'(1);
   assign recip   = {num_inc, 8'd0} + {8'd0, num_inc};
   assign quot    = recip[NumWidth+ChanWidth-1:NumWidth];

   always_comb begin
      if (mid.use_div) begin
         res_in = mid.invert ? CHAN_MAX - quot : quot;
      end else begin
         res_in = mid.direct;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

endmodule
`default_nettype wire

// ===== hdl/pixel_blend_unit_top.sv =====
// Top level of the pixel blend unit: input register, three blend lanes and result strobe.
//
//   channel   ports                       handshake
//   request   req_top_*, req_bottom_*     start high while busy low
//   result    rsp_out_*                   rsp_strobe, one cycle, no back-pressure
//   config    csr_wr_data                 csr_wr_en
//
// One item per cycle; busy stays low. Each item passes through the input register,
// the product register and the result register before it leaves.
// Synchronous active-high reset clears the mode register and the strobe pipeline.
// The receiver cannot stall, so no item is ever held back.
`default_nettype none
module pixel_blend_unit_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output      logic                          busy,
   input  wire logic [7:0]                    req_top_blue,
   input  wire logic [7:0]                    req_top_green,
   input  wire logic [7:0]                    req_top_red,
   input  wire logic [7:0]                    req_bottom_blue,
   input  wire logic [7:0]                    req_bottom_green,
   input  wire logic [7:0]                    req_bottom_red,
   input  wire logic                          csr_wr_en,
   input  wire logic [pbu_pkg::ModeWidth-1:0] csr_wr_data,
   output      logic                          rsp_strobe,
   output      logic [7:0]                    rsp_out_blue,
   output      logic [7:0]                    rsp_out_green,
   output      logic [7:0]                    rsp_out_red
);
   import pbu_pkg::*;

   logic [ModeWidth-1:0] blend_mode_ff;
   logic [ModeWidth-1:0] stage_mode_ff;
   chan_type             top_ff    [NumChans];
   chan_type             bottom_ff [NumChans];
   mid_type              mid       [NumChans];
   chan_type             res       [NumChans];
   logic                 in_vld_ff;
   logic                 mid_vld_ff;
   logic                 out_vld_ff;
   logic                 accept;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_mode_ff <= MODE_MULTIPLY;
         in_vld_ff     <= 1'b0;
         mid_vld_ff    <= 1'b0;
         out_vld_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            blend_mode_ff <= csr_wr_data;
         end
         in_vld_ff  <= accept;
         mid_vld_ff <= in_vld_ff;
         out_vld_ff <= mid_vld_ff;
      end
   end

   // hold the item and the mode it was taken under
   always_ff @(posedge clock) begin
      if (accept) begin
         stage_mode_ff <= blend_mode_ff;
         top_ff[0]     <= req_top_blue;
         top_ff[1]     <= req_top_green;
         top_ff[2]     <= req_top_red;
         bottom_ff[0]  <= req_bottom_blue;
         bottom_ff[1]  <= req_bottom_green;
         bottom_ff[2]  <= req_bottom_red;
      end
   end

   for (genvar ch = 0; ch < NumChans; ch++) begin : g_lane
      pbu_prod u_prod (
         .clock  (clock),
         .mode   (stage_mode_ff),
         .chan_a (top_ff[ch]),
         .chan_b (bottom_ff[ch]),
         .mid_ff (mid[ch])
      );

      pbu_scale u_scale (
         .clock  (clock),
         .mid    (mid[ch]),
         .res_ff (res[ch])
      );
   end

   assign rsp_strobe    = out_vld_ff;
   assign rsp_out_blue  = res[0];
   assign rsp_out_green = res[1];
   assign rsp_out_red   = res[2];

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for pixel_blend_unit_top: all blend modes, corners, random pixel pairs.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pbu_pkg::*;

   localparam int unsigned ChanMax      = CHAN_MAX;
   localparam int unsigned OverlaySplit = 128;
   localparam int unsigned RandomPixels = 2000;
   localparam int unsigned DrainCycles  = 8;
   localparam int unsigned ShownErrors  = 10;

   typedef logic [NumChans-1:0][ChanWidth-1:0] bgr_type;   // [0] blue, [1] green, [2] red

   typedef struct packed {
      bgr_type top;
      bgr_type bottom;
   } pixel_pair_type;

   logic                 clock;
   logic                 reset            = 1'b1;
   logic                 start            = 1'b0;
   logic                 busy;
   logic [7:0]           req_top_blue     = '0;
   logic [7:0]           req_top_green    = '0;
   logic [7:0]           req_top_red      = '0;
   logic [7:0]           req_bottom_blue  = '0;
   logic [7:0]           req_bottom_green = '0;
   logic [7:0]           req_bottom_red   = '0;
   logic                 csr_wr_en        = 1'b0;
   logic [ModeWidth-1:0] csr_wr_data      = '0;
   logic                 rsp_strobe;
   logic [7:0]           rsp_out_blue;
   logic [7:0]           rsp_out_green;
   logic [7:0]           rsp_out_red;

   logic [ModeWidth-1:0] mode_now = MODE_MULTIPLY;
   bgr_type              blended_q[$];
   int unsigned          error_count = 0;
   bit                   no_idle = 1'b0;

   pixel_blend_unit_top dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_top_blue     (req_top_blue),
      .req_top_green    (req_top_green),
      .req_top_red      (req_top_red),
      .req_bottom_blue  (req_bottom_blue),
      .req_bottom_green (req_bottom_green),
      .req_bottom_red   (req_bottom_red),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_out_blue     (rsp_out_blue),
      .rsp_out_green    (rsp_out_green),
      .rsp_out_red      (rsp_out_red)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("tb_top: errors");
      $finish;
   end

   function automatic int unsigned round_product(int unsigned a, int unsigned b);
      return (2 * a * b + ChanMax) / (2 * ChanMax);
   endfunction

   function automatic chan_type blend_chan(logic [ModeWidth-1:0] mode, chan_type a, chan_type b);
      int unsigned x;
      int unsigned y;
      int unsigned s;
      x = a;
      y = b;
      case (mode)
         MODE_MULTIPLY: s = round_product(x, y);
         MODE_SUBTRACT: s = (x > y) ? x - y : 0;
         MODE_ADD: begin
            s = x + y;
            if (s > ChanMax) s = ChanMax;
         end
         MODE_SCREEN:   s = ChanMax - round_product(ChanMax - x, ChanMax - y);
         MODE_OVERLAY: begin
            if (y < OverlaySplit) s = (2 * x * y) / ChanMax;
            else s = ChanMax - (2 * (ChanMax - x) * (ChanMax - y) + ChanMax - 1) / ChanMax;
         end
         default:       s = 0;
      endcase
      return s[ChanWidth-1:0];
   endfunction

   function automatic bgr_type blend_pixel(logic [ModeWidth-1:0] mode, pixel_pair_type p);
      bgr_type r;
      for (int ch = 0; ch < NumChans; ch++) r[ch] = blend_chan(mode, p.top[ch], p.bottom[ch]);
      return r;
   endfunction

   function automatic void note_error(string msg);
      if (error_count < ShownErrors) $display("%t mismatch: %s", $realtime, msg);
      error_count++;
   endfunction

   function automatic int unsigned idle_gap();
      int unsigned r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic chan_type random_chan();
      case ($urandom_range(0, 9))
         0:       return 8'd0;
         1:       return 8'd255;
         2:       return chan_type'($urandom_range(OverlaySplit - 2, OverlaySplit + 1));
         default: return chan_type'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic pixel_pair_type random_pair();
      pixel_pair_type p;
      for (int ch = 0; ch < NumChans; ch++) begin
         p.top[ch]    = random_chan();
         p.bottom[ch] = random_chan();
      end
      return p;
   endfunction

   // call just after a rising edge; start is left high for back-to-back items
   task automatic send_pixel(pixel_pair_type p);
      int unsigned gap;
      gap = idle_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_top_blue     <= p.top[0];
      req_top_green    <= p.top[1];
      req_top_red      <= p.top[2];
      req_bottom_blue  <= p.bottom[0];
      req_bottom_green <= p.bottom[1];
      req_bottom_red   <= p.bottom[2];
      @(posedge clock);
      while (busy) @(posedge clock);
      blended_q = {blended_q, blend_pixel(mode_now, p)};
   endtask

   task automatic drain_pixels();
      start <= 1'b0;
      while (blended_q.size() != 0) @(posedge clock);
   endtask

   task automatic set_blend_mode(logic [ModeWidth-1:0] mode);
      drain_pixels();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      mode_now = mode;
   endtask

   always @(posedge clock) begin : check_result
      bgr_type want;
      bgr_type got;
      string   names[NumChans];
      names = '{"blue", "green", "red"};
      got = {rsp_out_red, rsp_out_green, rsp_out_blue};
      if (!reset && rsp_strobe) begin
         if (blended_q.size() == 0) begin
            note_error($sformatf("unexpected result b=%0d g=%0d r=%0d", got[0], got[1], got[2]));
         end else begin
            want = blended_q.pop_front();
            for (int ch = 0; ch < NumChans; ch++) begin
               if (got[ch] !== want[ch])
                  note_error($sformatf("%s expected %0d got %0d", names[ch], want[ch], got[ch]));
            end
         end
      end
   end

   task automatic test_reset_mode();
      pixel_pair_type p;
      p.top    = {8'd200, 8'd255, 8'd17};
      p.bottom = {8'd100, 8'd255, 8'd240};
      send_pixel(p);
      send_pixel(random_pair());
   endtask

   task automatic test_corners();
      pixel_pair_type p;
      for (int m = 0; m < 8; m++) begin
         set_blend_mode(m[ModeWidth-1:0]);
         p.top    = {8'd255, 8'd255, 8'd0};
         p.bottom = {8'd255, 8'd0, 8'd255};
         send_pixel(p);
         p.top    = {8'd127, 8'd128, 8'd0};
         p.bottom = {8'd128, 8'd127, 8'd0};
         send_pixel(p);
      end
   endtask

   task automatic test_random_pixels();
      int unsigned          sent;
      int unsigned          phase_len;
      logic [ModeWidth-1:0] mode;
      sent = 0;
      while (sent < RandomPixels) begin
         if ($urandom_range(0, 9) < 8) mode = ModeWidth'($urandom_range(0, 4));
         else mode = ModeWidth'($urandom_range(5, 7));
         set_blend_mode(mode);
         no_idle   = ($urandom_range(0, 3) == 0);
         phase_len = $urandom_range(20, 200);
         for (int i = 0; i < phase_len && sent < RandomPixels; i++) begin
            send_pixel(random_pair());
            sent++;
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_mode();
      test_corners();
      test_random_pixels();
      drain_pixels();
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
